// ===== src/tlvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

   // record header layout
   localparam logic [1:0]  HDR_TAG_POS   = 2'd0;
   localparam logic [1:0]  HDR_TYPE_POS  = 2'd1;
   localparam logic [1:0]  HDR_LEN_LO    = 2'd2;
   localparam logic [1:0]  HDR_LEN_HI    = 2'd3;

   // record codes that carry a captured value
   localparam logic [7:0]  TAG_CMD       = 8'h10;
   localparam logic [7:0]  TAG_RES_CMD   = 8'h20;
   localparam logic [7:0]  TAG_RES_CODE  = 8'h21;
   localparam logic [7:0]  TYPE_U16      = 8'h02;
   localparam logic [15:0] LEN_U16       = 16'd2;

   // parse modes
   localparam logic MODE_COMMAND = 1'b0;
   localparam logic MODE_RESULT  = 1'b1;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_VALUE  = 2'd1
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE         = 2'd0,
      KIND_CMD_MODE_CMD = 2'd1,
      KIND_RES_MODE_CMD = 2'd2,
      KIND_RES_MODE_RES = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TRUNC   = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== src/tlvp_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

// payload byte channel
interface tlvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// parse result channel
interface tlvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] command_id;
   logic [15:0] reply_code;

   modport source (output valid, output status, output command_id, output reply_code,
                   input ready);
   modport sink   (input valid, input status, input command_id, input reply_code,
                   output ready);
endinterface

// mode register write channel
interface tlvp_csr_if;
   logic valid;
   logic ready;
   logic parse_mode;

   modport source (output valid, output parse_mode, input ready);
   modport sink   (input valid, input parse_mode, output ready);
endinterface

`default_nettype wire

// ===== src/tlv_control_payload_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// latency: a result appears in the cycle after the final payload byte is transferred
// throughput: one payload byte per cycle; the per-byte header/value update is a
//   single register stage, and a held result stalls input only when not taken
// reset: synchronous, active high; clears parse state, result valid and mode (command)
module tlv_control_payload_parser (
   input  wire         clock,
   input  wire         reset,
   tlvp_req_if.sink    req_chan,
   tlvp_rsp_if.source  rsp_chan,
   tlvp_csr_if.sink    csr_chan
);

   // parse state
   logic                  parse_mode_ff, parse_mode_in;
   tlvp_pkg::phase_type   phase_ff, phase_in;
   logic [1:0]            header_count_ff, header_count_in;
   logic [7:0]            record_tag_ff, record_tag_in;
   logic [7:0]            record_type_ff, record_type_in;
   logic [15:0]           record_length_ff, record_length_in;
   logic [15:0]           value_remaining_ff, value_remaining_in;
   tlvp_pkg::kind_type    capture_kind_ff, capture_kind_in;
   logic [7:0]            value_low_byte_ff, value_low_byte_in;
   logic [15:0]           captured_command_ff, captured_command_in;
   logic [15:0]           captured_result_ff, captured_result_in;
   logic                  have_command_ff, have_command_in;
   logic                  have_result_ff, have_result_in;
   logic                  matched_done_ff, matched_done_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   tlvp_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [15:0]           rsp_command_ff, rsp_command_in;
   logic [15:0]           rsp_result_ff, rsp_result_in;

   logic                  req_xfer;
   logic                  emit;
   logic                  in_value;
   logic [15:0]           full_length;
   logic [15:0]           value_word;

   // input is taken whenever the result register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign emit           = req_xfer && req_chan.last_byte;
   assign csr_chan.ready = 1'b1;

   assign in_value    = (phase_ff == tlvp_pkg::PHASE_VALUE) && (value_remaining_ff != 16'd0);
   assign full_length = {req_chan.data_byte, record_length_ff[7:0]};
   assign value_word  = {req_chan.data_byte, value_low_byte_ff};

   // mode register
   always_comb begin
      parse_mode_in = parse_mode_ff;
      if (csr_chan.valid) begin
         parse_mode_in = csr_chan.parse_mode;
      end
   end

   // per-byte record walk and result build
   always_comb begin
      phase_in            = phase_ff;
      header_count_in     = header_count_ff;
      record_tag_in       = record_tag_ff;
      record_type_in      = record_type_ff;
      record_length_in    = record_length_ff;
      value_remaining_in  = value_remaining_ff;
      capture_kind_in     = capture_kind_ff;
      value_low_byte_in   = value_low_byte_ff;
      captured_command_in = captured_command_ff;
      captured_result_in  = captured_result_ff;
      have_command_in     = have_command_ff;
      have_result_in      = have_result_ff;
      matched_done_in     = matched_done_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_command_in      = rsp_command_ff;
      rsp_result_in       = rsp_result_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_chan.ready;

      if (req_xfer && !matched_done_ff) begin
         if (in_value) begin
            // value byte
            if ((value_remaining_ff == 16'd2) && (capture_kind_ff != tlvp_pkg::KIND_NONE)) begin
               value_low_byte_in = req_chan.data_byte;
            end
            value_remaining_in = value_remaining_ff - 16'd1;
            if (value_remaining_ff == 16'd1) begin
               case (capture_kind_ff)
                  tlvp_pkg::KIND_CMD_MODE_CMD: begin
                     captured_command_in = value_word;
                     have_command_in     = 1'b1;
                     matched_done_in     = 1'b1;
                  end
                  tlvp_pkg::KIND_RES_MODE_CMD: begin
                     captured_command_in = value_word;
                     have_command_in     = 1'b1;
                  end
                  tlvp_pkg::KIND_RES_MODE_RES: begin
                     captured_result_in = value_word;
                     have_result_in     = 1'b1;
                  end
                  default: begin
                  end
               endcase
               capture_kind_in = tlvp_pkg::KIND_NONE;
               phase_in        = tlvp_pkg::PHASE_HEADER;
            end
         end else begin
            // header byte
            unique case (header_count_ff)
               tlvp_pkg::HDR_TAG_POS: begin
                  record_tag_in   = req_chan.data_byte;
                  header_count_in = tlvp_pkg::HDR_TYPE_POS;
               end
               tlvp_pkg::HDR_TYPE_POS: begin
                  record_type_in  = req_chan.data_byte;
                  header_count_in = tlvp_pkg::HDR_LEN_LO;
               end
               tlvp_pkg::HDR_LEN_LO: begin
                  record_length_in = {8'd0, req_chan.data_byte};
                  header_count_in  = tlvp_pkg::HDR_LEN_HI;
               end
               default: begin
                  record_length_in   = full_length;
                  header_count_in    = tlvp_pkg::HDR_TAG_POS;
                  value_remaining_in = full_length;
                  capture_kind_in    = tlvp_pkg::KIND_NONE;
                  if ((record_type_ff == tlvp_pkg::TYPE_U16) &&
                      (full_length == tlvp_pkg::LEN_U16)) begin
                     if (parse_mode_ff == tlvp_pkg::MODE_COMMAND) begin
                        if (record_tag_ff == tlvp_pkg::TAG_CMD) begin
                           capture_kind_in = tlvp_pkg::KIND_CMD_MODE_CMD;
                        end
                     end else begin
                        if (record_tag_ff == tlvp_pkg::TAG_RES_CMD) begin
                           capture_kind_in = tlvp_pkg::KIND_RES_MODE_CMD;
                        end else if (record_tag_ff == tlvp_pkg::TAG_RES_CODE) begin
                           capture_kind_in = tlvp_pkg::KIND_RES_MODE_RES;
                        end
                     end
                  end
                  phase_in = (full_length != 16'd0) ? tlvp_pkg::PHASE_VALUE
                                                    : tlvp_pkg::PHASE_HEADER;
               end
            endcase
         end
      end

      // final byte: build result from updated state, then start a fresh payload
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = 16'd0;
         rsp_result_in  = 16'd0;
         if (parse_mode_ff == tlvp_pkg::MODE_COMMAND) begin
            if (matched_done_in) begin
               rsp_status_in  = tlvp_pkg::ST_OK;
               rsp_command_in = captured_command_in;
            end else if ((phase_in == tlvp_pkg::PHASE_VALUE) &&
                         (value_remaining_in != 16'd0)) begin
               rsp_status_in = tlvp_pkg::ST_TRUNC;
            end else begin
               rsp_status_in = tlvp_pkg::ST_MISSING;
            end
         end else begin
            if (!matched_done_in && (phase_in == tlvp_pkg::PHASE_VALUE) &&
                (value_remaining_in != 16'd0)) begin
               rsp_status_in = tlvp_pkg::ST_TRUNC;
            end else if (have_command_in && have_result_in) begin
               rsp_status_in  = tlvp_pkg::ST_OK;
               rsp_command_in = captured_command_in;
               rsp_result_in  = captured_result_in;
            end else begin
               rsp_status_in = tlvp_pkg::ST_MISSING;
            end
         end

         phase_in            = tlvp_pkg::PHASE_HEADER;
         header_count_in     = tlvp_pkg::HDR_TAG_POS;
         record_tag_in       = 8'd0;
         record_type_in      = 8'd0;
         record_length_in    = 16'd0;
         value_remaining_in  = 16'd0;
         capture_kind_in     = tlvp_pkg::KIND_NONE;
         value_low_byte_in   = 8'd0;
         captured_command_in = 16'd0;
         captured_result_in  = 16'd0;
         have_command_in     = 1'b0;
         have_result_in      = 1'b0;
         matched_done_in     = 1'b0;
      end
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_mode_ff       <= tlvp_pkg::MODE_COMMAND;
         phase_ff            <= tlvp_pkg::PHASE_HEADER;
         header_count_ff     <= tlvp_pkg::HDR_TAG_POS;
         record_tag_ff       <= 8'd0;
         record_type_ff      <= 8'd0;
         record_length_ff    <= 16'd0;
         value_remaining_ff  <= 16'd0;
         capture_kind_ff     <= tlvp_pkg::KIND_NONE;
         value_low_byte_ff   <= 8'd0;
         captured_command_ff <= 16'd0;
         captured_result_ff  <= 16'd0;
         have_command_ff     <= 1'b0;
         have_result_ff      <= 1'b0;
         matched_done_ff     <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         parse_mode_ff       <= parse_mode_in;
         phase_ff            <= phase_in;
         header_count_ff     <= header_count_in;
         record_tag_ff       <= record_tag_in;
         record_type_ff      <= record_type_in;
         record_length_ff    <= record_length_in;
         value_remaining_ff  <= value_remaining_in;
         capture_kind_ff     <= capture_kind_in;
         value_low_byte_ff   <= value_low_byte_in;
         captured_command_ff <= captured_command_in;
         captured_result_ff  <= captured_result_in;
         have_command_ff     <= have_command_in;
         have_result_ff      <= have_result_in;
         matched_done_ff     <= matched_done_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_command_ff <= rsp_command_in;
      rsp_result_ff  <= rsp_result_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.command_id = rsp_command_ff;
   assign rsp_chan.reply_code = rsp_result_ff;

endmodule

`default_nettype wire
